@@ sv/pte_pkg.sv @@
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types and constants for the phasor-timed value easer.
// ----------------------------------------------------------------------------
package pte_pkg;

	localparam int CHANNEL_BITS   = 8;
	localparam int CHANNELS_DEF   = 256;
	localparam int LEVEL_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 2;

	typedef enum logic [1:0] {
		KIND_PASS,
		KIND_FIRST,
		KIND_EASE
	} item_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SQUARE,
		ST_WEIGHT,
		ST_BLEND,
		ST_RESULT
	} back_state_t;

endpackage

@@ sv/pte_in_if.sv @@
// ----------------------------------------------------------------------------
// pte_in_if
// Tick channel: channel index, phasor position and target level.
// ----------------------------------------------------------------------------
interface pte_in_if
	import pte_pkg::*;
	#(parameter int LEVEL_BITS = LEVEL_BITS_DEF)
	();

	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] channel;
	logic [LEVEL_BITS-1:0]   phasor_value;
	logic [LEVEL_BITS-1:0]   target_level;

	modport source (output valid, channel, phasor_value, target_level, input ready);
	modport sink   (input valid, channel, phasor_value, target_level, output ready);

endinterface

@@ sv/pte_out_if.sv @@
// ----------------------------------------------------------------------------
// pte_out_if
// Result channel: channel index and eased level.
// ----------------------------------------------------------------------------
interface pte_out_if
	import pte_pkg::*;
	#(parameter int LEVEL_BITS = LEVEL_BITS_DEF)
	();

	logic                    valid;
	logic                    ready;
	logic [CHANNEL_BITS-1:0] out_channel;
	logic [LEVEL_BITS-1:0]   eased_level;

	modport source (output valid, out_channel, eased_level, input ready);
	modport sink   (input valid, out_channel, eased_level, output ready);

endinterface

@@ sv/pte_front.sv @@
// ----------------------------------------------------------------------------
// pte_front
// Accepts ticks, classifies them (out of range, first tick, tracked) and
// keeps the per-channel seen flags.
// ----------------------------------------------------------------------------
module pte_front
	import pte_pkg::*;
	#(
		parameter int CHANNELS   = CHANNELS_DEF
	)
	(
		input  logic                    clk,
		input  logic                    arst_n,
		pte_in_if.sink                  item,
		input  logic                    q_full,
		output logic                    push,
		output item_kind_t              push_kind
	);

	localparam int SEEN_D = (CHANNELS < (1 << CHANNEL_BITS)) ? CHANNELS : (1 << CHANNEL_BITS);
	localparam int IDX_W  = (SEEN_D > 1) ? $clog2(SEEN_D) : 1;

	logic [SEEN_D-1:0] seen_q;
	logic              in_range;
	logic [IDX_W-1:0]  idx;

	assign item.ready = !q_full;
	assign push       = item.valid && !q_full;
	assign in_range   = int'(item.channel) < SEEN_D;
	assign idx        = IDX_W'(item.channel);

	always_comb begin
		if (!in_range) begin
			push_kind = KIND_PASS;
		end else if (seen_q[idx]) begin
			push_kind = KIND_EASE;
		end else begin
			push_kind = KIND_FIRST;
		end
	end

	// mark the channel at transfer time; the queue keeps order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (push && in_range) begin
			seen_q[idx] <= 1'b1;
		end
	end

endmodule

@@ sv/pte_queue.sv @@
// ----------------------------------------------------------------------------
// pte_queue
// Short FIFO between the classifying front and the easing back end.
// ----------------------------------------------------------------------------
module pte_queue
	import pte_pkg::*;
	#(
		parameter int DEPTH      = QUEUE_DEPTH,
		parameter int LEVEL_BITS = LEVEL_BITS_DEF
	)
	(
		input  logic                    clk,
		input  logic                    arst_n,
		input  logic                    push,
		input  item_kind_t              push_kind,
		input  logic [CHANNEL_BITS-1:0] push_ch,
		input  logic [LEVEL_BITS-1:0]   push_ph,
		input  logic [LEVEL_BITS-1:0]   push_tg,
		output logic                    full,
		input  logic                    pop,
		output item_kind_t              head_kind,
		output logic [CHANNEL_BITS-1:0] head_ch,
		output logic [LEVEL_BITS-1:0]   head_ph,
		output logic [LEVEL_BITS-1:0]   head_tg,
		output logic                    empty
	);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_kind_t              kind_q [DEPTH];
	logic [CHANNEL_BITS-1:0] ch_q   [DEPTH];
	logic [LEVEL_BITS-1:0]   ph_q   [DEPTH];
	logic [LEVEL_BITS-1:0]   tg_q   [DEPTH];
	logic [PTR_W-1:0]        wr_ptr_q;
	logic [PTR_W-1:0]        rd_ptr_q;
	logic [CNT_W-1:0]        count_q;

	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign head_kind = kind_q[rd_ptr_q];
	assign head_ch   = ch_q[rd_ptr_q];
	assign head_ph   = ph_q[rd_ptr_q];
	assign head_tg   = tg_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			kind_q[wr_ptr_q] <= push_kind;
			ch_q[wr_ptr_q]   <= push_ch;
			ph_q[wr_ptr_q]   <= push_ph;
			tg_q[wr_ptr_q]   <= push_tg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ sv/pte_back.sv @@
// ----------------------------------------------------------------------------
// pte_back
// Per-channel state memory, ease weight and blend datapath, result register.
// ----------------------------------------------------------------------------
module pte_back
	import pte_pkg::*;
	#(
		parameter int CHANNELS   = CHANNELS_DEF,
		parameter int LEVEL_BITS = LEVEL_BITS_DEF
	)
	(
		input  logic                    clk,
		input  logic                    arst_n,
		input  logic                    q_empty,
		input  item_kind_t              head_kind,
		input  logic [CHANNEL_BITS-1:0] head_ch,
		input  logic [LEVEL_BITS-1:0]   head_ph,
		input  logic [LEVEL_BITS-1:0]   head_tg,
		output logic                    pop,
		pte_out_if.source               result
	);

	localparam int L      = LEVEL_BITS;
	localparam int MEM_D  = (CHANNELS < (1 << CHANNEL_BITS)) ? CHANNELS : (1 << CHANNEL_BITS);
	localparam int IDX_W  = (MEM_D > 1) ? $clog2(MEM_D) : 1;
	localparam int WORD_W = 5 * L + 1;
	localparam int P_W    = 2 * L + 3;

	// word layout: previous target, start value, start phase, highest phase,
	// done flag, current output
	localparam int OFS_CUR  = 0;
	localparam int OFS_DONE = L;
	localparam int OFS_HI   = L + 1;
	localparam int OFS_SP   = 2 * L + 1;
	localparam int OFS_SV   = 3 * L + 1;
	localparam int OFS_PREV = 4 * L + 1;

	logic [WORD_W-1:0]       mem [MEM_D];
	logic [WORD_W-1:0]       rd_q;
	back_state_t             state_q;
	back_state_t             state_d;
	logic                    commit;
	logic                    mem_we;
	logic                    out_free;

	item_kind_t              kind_q;
	logic [CHANNEL_BITS-1:0] ch_q;
	logic [L-1:0]            ph_q;
	logic [L-1:0]            tg_q;
	logic [L-1:0]            sv_q;
	logic [L-1:0]            sp_q;
	logic [L-1:0]            hi_q;
	logic                    dn_q;
	logic                    upper_q;
	logic [L-1:0]            tsel_q;
	logic signed [L:0]       diff_q;
	logic [2*L-1:0]          sq_q;
	logic [L:0]              e_q;
	logic signed [P_W-1:0]   prod_q;

	logic                    out_valid_q;
	logic [CHANNEL_BITS-1:0] out_ch_q;
	logic [L-1:0]            out_lvl_q;

	logic                    chg;
	logic [L-1:0]            sv_n;
	logic [L-1:0]            sp_n;
	logic [L-1:0]            hi_n;
	logic                    dn_n;
	logic [L-1:0]            t;
	logic                    wrap;
	logic [2*L:0]            sq_rnd;
	logic [L:0]              e_part;
	logic signed [P_W-1:0]   acc;
	logic [L-1:0]            blended;
	logic [L-1:0]            level;
	logic [WORD_W-1:0]       wr_word;

	assign out_free = !out_valid_q || result.ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					state_d = (head_kind == KIND_EASE) ? ST_LOOK : ST_RESULT;
				end
			end
			ST_LOOK:   state_d = ST_SQUARE;
			ST_SQUARE: state_d = ST_WEIGHT;
			ST_WEIGHT: state_d = ST_BLEND;
			ST_BLEND:  state_d = ST_RESULT;
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop    = 1'b0;
		commit = 1'b0;
		case (state_q)
			ST_IDLE:   pop    = !q_empty;
			ST_RESULT: commit = out_free;
			default: begin
				pop    = 1'b0;
				commit = 1'b0;
			end
		endcase
		mem_we = commit && (kind_q != KIND_PASS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// state memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[IDX_W'(ch_q)] <= wr_word;
		end
		if (pop) begin
			rd_q <= mem[IDX_W'(head_ch)];
		end
	end

	// restart on target change, then track the elapsed phase
	always_comb begin
		chg  = rd_q[OFS_PREV +: L] != tg_q;
		sv_n = chg ? rd_q[OFS_CUR +: L] : rd_q[OFS_SV +: L];
		sp_n = chg ? ph_q : rd_q[OFS_SP +: L];
		hi_n = chg ? '0 : rd_q[OFS_HI +: L];
		dn_n = chg ? 1'b0 : rd_q[OFS_DONE];
		t    = ph_q - sp_n;
		wrap = t < hi_n;
	end

	// ease weight from the square, then blend
	always_comb begin
		sq_rnd  = {1'b0, sq_q} + ((2 * L + 1)'(1) << (L - 2));
		e_part  = (L + 1)'(sq_rnd >> (L - 1));
		acc     = $signed({3'b000, sv_q, L'(0)}) + prod_q + ($signed(P_W'(1)) <<< (L - 1));
		blended = acc[2*L-1:L];
		if (kind_q != KIND_EASE || dn_q) begin
			level = tg_q;
		end else begin
			level = blended;
		end
		if (kind_q == KIND_FIRST) begin
			wr_word = {tg_q, tg_q, ph_q, L'(0), 1'b0, tg_q};
		end else begin
			wr_word = {tg_q, sv_q, sp_q, hi_q, dn_q, level};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= head_kind;
			ch_q   <= head_ch;
			ph_q   <= head_ph;
			tg_q   <= head_tg;
		end
		if (state_q == ST_LOOK) begin
			sv_q    <= sv_n;
			sp_q    <= sp_n;
			hi_q    <= wrap ? hi_n : t;
			dn_q    <= dn_n || wrap;
			upper_q <= t[L-1];
			tsel_q  <= t[L-1] ? (L'(0) - t) : t;
			diff_q  <= $signed({1'b0, tg_q}) - $signed({1'b0, sv_n});
		end
		if (state_q == ST_SQUARE) begin
			sq_q <= (2 * L)'(tsel_q) * (2 * L)'(tsel_q);
		end
		if (state_q == ST_WEIGHT) begin
			e_q <= upper_q ? (((L + 1)'(1) << L) - e_part) : e_part;
		end
		if (state_q == ST_BLEND) begin
			prod_q <= P_W'(diff_q) * P_W'($signed({1'b0, e_q}));
		end
		if (commit) begin
			out_ch_q  <= ch_q;
			out_lvl_q <= level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_channel = out_ch_q;
	assign result.eased_level = out_lvl_q;

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("pop from an empty queue");

	a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != ST_IDLE)
		else $error("back end stayed idle after taking an item");

	a_square_after_look: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQUARE |-> $past(state_q) == ST_LOOK)
		else $error("square stage entered without a phase lookup");

	a_blend_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && kind_q == KIND_EASE && !dn_q) |->
		((level >= tg_q && level <= sv_q) || (level >= sv_q && level <= tg_q)))
		else $error("eased level outside start and target");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> result.valid && result.out_channel == $past(ch_q))
		else $error("result transfer lost its channel");

endmodule

@@ sv/phasor_timed_value_easer.sv @@
// ----------------------------------------------------------------------------
// phasor_timed_value_easer
// Per-channel quadratic ease-in-out of lighting levels, timed by a phasor.
//
//   port     role    carries
//   item     sink    channel, phasor_value, target_level
//   result   source  out_channel, eased_level
//
// A tick for a tracked channel passes through these back-end steps in order:
// state memory read, phase tracking, square, weight, blend, result. A first
// tick or an out-of-range channel goes from idle straight to the result.
// The back end handles one tick at a time. Reset clears the seen flags at
// once; the state memory needs no clearing. A stalled result holds the back
// end; the front keeps filling its two-entry queue.
// ----------------------------------------------------------------------------
module phasor_timed_value_easer
	import pte_pkg::*;
	#(
		parameter int CHANNELS   = CHANNELS_DEF,
		parameter int LEVEL_BITS = LEVEL_BITS_DEF
	)
	(
		input  logic      clk,
		input  logic      arst_n,
		pte_in_if.sink    item,
		pte_out_if.source result
	);

	logic                    push;
	item_kind_t              push_kind;
	logic                    q_full;
	logic                    q_empty;
	logic                    pop;
	item_kind_t              head_kind;
	logic [CHANNEL_BITS-1:0] head_ch;
	logic [LEVEL_BITS-1:0]   head_ph;
	logic [LEVEL_BITS-1:0]   head_tg;

	pte_front #(
		.CHANNELS   (CHANNELS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.q_full    (q_full),
		.push      (push),
		.push_kind (push_kind)
	);

	pte_queue #(
		.DEPTH      (QUEUE_DEPTH),
		.LEVEL_BITS (LEVEL_BITS)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_kind (push_kind),
		.push_ch   (item.channel),
		.push_ph   (item.phasor_value),
		.push_tg   (item.target_level),
		.full      (q_full),
		.pop       (pop),
		.head_kind (head_kind),
		.head_ch   (head_ch),
		.head_ph   (head_ph),
		.head_tg   (head_tg),
		.empty     (q_empty)
	);

	pte_back #(
		.CHANNELS   (CHANNELS),
		.LEVEL_BITS (LEVEL_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head_kind (head_kind),
		.head_ch   (head_ch),
		.head_ph   (head_ph),
		.head_tg   (head_tg),
		.pop       (pop),
		.result    (result)
	);

endmodule

@@ test/tb_phasor_timed_value_easer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_phasor_timed_value_easer
// Self-checking bench for the per-channel quadratic ease-in-out block.
//
// A short table of directed ticks covers first ticks, level extremes, target
// changes, a standing phasor and phase wrap. Random traffic follows: mostly
// well-formed per-channel phasor sweeps with held targets, mixed with noise.
// Every result is checked in order against a local model of the channel
// state, with random gaps on the tick side, random stalls on the result side
// and one long result stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_phasor_timed_value_easer;
	import pte_pkg::*;

	localparam int LVL          = LEVEL_BITS_DEF;
	localparam int LANES        = 1 << CHANNEL_BITS;
	localparam int NUM_DIRECTED = 22;
	localparam int RANDOM_ITEMS = 930;
	localparam int TAIL_ITEMS   = 150;
	localparam int HOT_COUNT    = 8;
	localparam int DRAIN_CYCLES = 24;
	localparam int LONG_HOLD    = 400;
	localparam int HOLD_AFTER   = 300;

	localparam logic [63:0] FULL = 64'd1 << LVL;
	localparam logic [63:0] HALF = FULL >> 1;
	localparam logic [63:0] RND  = 64'd1 << (LVL - 2);

	typedef logic [CHANNEL_BITS-1:0] lane_t;
	typedef logic [LVL-1:0]          level_t;

	typedef struct {
		lane_t  channel;
		level_t phasor;
		level_t target;
		bit     known;
		level_t level;
	} tick_row_t;

	typedef struct {
		lane_t  channel;
		level_t level;
	} eased_t;

	logic clk;
	logic arst_n;

	pte_in_if  #(.LEVEL_BITS(LVL)) item_bus ();
	pte_out_if #(.LEVEL_BITS(LVL)) result_bus ();

	phasor_timed_value_easer #(
		.CHANNELS  (CHANNELS_DEF),
		.LEVEL_BITS(LVL)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_bus),
		.result(result_bus)
	);

	// channel state as the block should hold it
	bit     lane_seen   [LANES];
	level_t last_target [LANES];
	level_t ease_from   [LANES];
	level_t ease_phase0 [LANES];
	level_t peak_phase  [LANES];
	bit     lane_settled[LANES];
	level_t lane_level  [LANES];

	// stimulus-side per-channel sweep
	level_t sweep_phase [LANES];
	level_t sweep_target[LANES];
	lane_t  hot_lanes   [HOT_COUNT];

	eased_t pending_levels[$];
	int     fail_count;
	int     results_seen;
	bit     steady_tail;

	tick_row_t directed_rows [NUM_DIRECTED] = '{
		'{8'd0,   16'h0000, 16'h0000, 1'b1, 16'h0000},
		'{8'd255, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF},
		'{8'd0,   16'h1000, 16'hFFFF, 1'b1, 16'h0000},
		'{8'd0,   16'h1000, 16'hFFFF, 1'b1, 16'h0000},
		'{8'd0,   16'h5000, 16'hFFFF, 1'b0, 16'h0000},
		'{8'd0,   16'h9000, 16'hFFFF, 1'b0, 16'h0000},
		'{8'd0,   16'hF000, 16'hFFFF, 1'b0, 16'h0000},
		'{8'd0,   16'h0FFF, 16'hFFFF, 1'b1, 16'hFFFF},
		'{8'd0,   16'h1000, 16'hFFFF, 1'b1, 16'hFFFF},
		'{8'd0,   16'h8000, 16'hFFFF, 1'b1, 16'hFFFF},
		'{8'd255, 16'h0000, 16'h0000, 1'b1, 16'hFFFF},
		'{8'd255, 16'h4000, 16'h0000, 1'b0, 16'h0000},
		'{8'd255, 16'h8000, 16'h0000, 1'b0, 16'h0000},
		'{8'd255, 16'h7FFF, 16'h0000, 1'b1, 16'h0000},
		'{8'd255, 16'h1234, 16'h8000, 1'b1, 16'h0000},
		'{8'd255, 16'h5234, 16'h8000, 1'b0, 16'h0000},
		'{8'd255, 16'h6000, 16'h0000, 1'b0, 16'h0000},
		'{8'd1,   16'hAAAA, 16'h5555, 1'b1, 16'h5555},
		'{8'd1,   16'h5555, 16'hAAAA, 1'b1, 16'h5555},
		'{8'd1,   16'h5554, 16'hAAAA, 1'b0, 16'h0000},
		'{8'd128, 16'h8000, 16'h8000, 1'b1, 16'h8000},
		'{8'd128, 16'h8000, 16'h8000, 1'b1, 16'h8000}
	};

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [63:0] curve_weight(level_t t);
		logic [63:0] t64;
		logic [63:0] u;
		t64 = 64'(t);
		if (t64 < HALF) begin
			return (t64 * t64 + RND) >> (LVL - 1);
		end
		u = FULL - t64;
		return FULL - ((u * u + RND) >> (LVL - 1));
	endfunction

	function automatic level_t ease_tick(lane_t ch, level_t ph, level_t tg);
		logic [63:0] e;
		logic [63:0] acc;
		level_t      t;
		level_t      lvl;
		if (ch >= CHANNELS_DEF) begin
			return tg;
		end
		if (!lane_seen[ch]) begin
			lane_seen[ch]    = 1'b1;
			last_target[ch]  = tg;
			ease_from[ch]    = tg;
			ease_phase0[ch]  = ph;
			peak_phase[ch]   = '0;
			lane_settled[ch] = 1'b0;
			lane_level[ch]   = tg;
			return tg;
		end
		if (last_target[ch] != tg) begin
			ease_phase0[ch]  = ph;
			lane_settled[ch] = 1'b0;
			peak_phase[ch]   = '0;
			ease_from[ch]    = lane_level[ch];
		end
		t = ph - ease_phase0[ch];
		if (t < peak_phase[ch]) begin
			lane_settled[ch] = 1'b1;
		end else begin
			peak_phase[ch] = t;
		end
		if (!lane_settled[ch]) begin
			e   = curve_weight(t);
			acc = 64'(ease_from[ch]) * (FULL - e) + 64'(tg) * e + HALF;
			lvl = level_t'(acc >> LVL);
		end else begin
			lvl = tg;
		end
		last_target[ch] = tg;
		lane_level[ch]  = lvl;
		return lvl;
	endfunction

	task automatic send_tick(lane_t ch, level_t ph, level_t tg, bit known, level_t lvl);
		eased_t item;
		level_t predicted;
		item_bus.valid        <= 1'b1;
		item_bus.channel      <= ch;
		item_bus.phasor_value <= ph;
		item_bus.target_level <= tg;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		predicted    = ease_tick(ch, ph, tg);
		item.channel = ch;
		item.level   = known ? lvl : predicted;
		pending_levels.push_back(item);
	endtask

	task automatic idle_sender();
		if (!steady_tail && $urandom_range(0, 4) == 0) begin
			item_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		lane_t  ch;
		level_t ph;
		level_t tg;
		int     pick;
		item_bus.valid        = 1'b0;
		item_bus.channel      = '0;
		item_bus.phasor_value = '0;
		item_bus.target_level = '0;
		steady_tail           = 1'b0;
		fail_count            = 0;
		arst_n                = 1'b0;
		for (int k = 0; k < HOT_COUNT; k++) begin
			hot_lanes[k] = lane_t'($urandom_range(0, LANES - 1));
		end
		for (int k = 0; k < LANES; k++) begin
			sweep_phase[k]  = '0;
			sweep_target[k] = level_t'($urandom_range(0, 16'hFFFF));
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[r]) begin
			send_tick(directed_rows[r].channel, directed_rows[r].phasor,
				directed_rows[r].target, directed_rows[r].known, directed_rows[r].level);
			idle_sender();
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i >= RANDOM_ITEMS - TAIL_ITEMS) begin
				steady_tail = 1'b1;
			end
			if ($urandom_range(0, 99) == 0) begin
				hot_lanes[$urandom_range(0, HOT_COUNT - 1)] = lane_t'($urandom_range(0, LANES - 1));
			end
			if ($urandom_range(0, 99) < 85) begin
				ch   = hot_lanes[$urandom_range(0, HOT_COUNT - 1)];
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					ph = sweep_phase[ch];
				end else if (pick == 1) begin
					ph = sweep_phase[ch] + level_t'($urandom_range(0, 16'hFFFF));
				end else begin
					ph = sweep_phase[ch] + level_t'($urandom_range(1, 16'h2000));
				end
				sweep_phase[ch] = ph;
				if ($urandom_range(0, 9) == 0) begin
					case ($urandom_range(0, 3))
						0: sweep_target[ch] = '0;
						1: sweep_target[ch] = '1;
						default: sweep_target[ch] = level_t'($urandom_range(0, 16'hFFFF));
					endcase
				end
				tg = sweep_target[ch];
			end else begin
				ch = lane_t'($urandom_range(0, LANES - 1));
				ph = level_t'($urandom_range(0, 16'hFFFF));
				tg = level_t'($urandom_range(0, 16'hFFFF));
			end
			send_tick(ch, ph, tg, 1'b0, '0);
			idle_sender();
		end

		item_bus.valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin : result_side
		eased_t want;
		int     stall_left;
		bit     long_hold_done;
		result_bus.ready = 1'b0;
		results_seen     = 0;
		stall_left       = 0;
		long_hold_done   = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (result_bus.valid && result_bus.ready) begin
				results_seen++;
				if (pending_levels.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result: channel %0d level %h",
							result_bus.out_channel, result_bus.eased_level);
					end
				end else begin
					want = pending_levels.pop_front();
					if (result_bus.out_channel !== want.channel) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("out_channel mismatch: expected %0d actual %0d",
								want.channel, result_bus.out_channel);
						end
					end
					if (result_bus.eased_level !== want.level) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("eased_level mismatch on channel %0d: expected %h actual %h",
								want.channel, want.level, result_bus.eased_level);
						end
					end
				end
			end
			if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				stall_left     = LONG_HOLD;
			end else if (stall_left == 0 && !steady_tail && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 11);
			end
			if (stall_left > 0) begin
				result_bus.ready <= 1'b0;
				stall_left--;
			end else begin
				result_bus.ready <= 1'b1;
			end
		end
	end

endmodule

@@ files.f @@
sv/pte_pkg.sv
sv/pte_in_if.sv
sv/pte_out_if.sv
sv/pte_front.sv
sv/pte_queue.sv
sv/pte_back.sv
sv/phasor_timed_value_easer.sv
test/tb_phasor_timed_value_easer.sv
